// File: rtl/gsbc_pkg.sv
// ---------------------------------------------------------------------------
// gsbc_pkg
// Shared widths, codes, reset values and control types of the gyro static
// bias calibrator.
// ---------------------------------------------------------------------------
package gsbc_pkg;

    // default parameter values
    localparam int WINDOW_LIMIT_DEF = 1023;
    localparam int SAMPLE_BITS_DEF  = 16;

    // fixed field widths
    localparam int CNT_W      = 10;
    localparam int LIMIT_W    = 30;
    localparam int OLD_W      = 24;
    localparam int BIAS_W     = 25;
    localparam int VAR_W      = 31;
    localparam int OUTC_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DEN_W      = 2 * CNT_W + 2;

    // outcome codes
    localparam logic [OUTC_W-1:0] OUTC_STILL  = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_MOVING = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_FEW    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_Z  = 3'd5;

    // configuration reset values
    localparam logic [CNT_W-1:0]   WINDOW_RST = 10'd520;
    localparam logic [CNT_W-1:0]   MIN_RST    = 10'd200;
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 30'd9646;

    // sequencer states
    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_MUL,
        ST_SUB,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } state_t;

    // strobes from the sequencer to the lanes and the merge stage
    typedef struct packed {
        logic smp_load;
        logic clear;
        logic mul;
        logic sub;
        logic div_init;
        logic div_step;
    } lane_ctl_t;

endpackage

// File: rtl/gyro_static_bias_calibrator.sv
// ---------------------------------------------------------------------------
// gyro_static_bias_calibrator
// Zero-rate bias calibration over a window of gyro read attempts, with three
// axis lanes and a merge stage for the variance test.
//
// channel  signals                                       direction
// in       in_valid/in_ready, read_ok, raw_x/y/z         sensor -> block
// out      out_valid/out_ready, outcome, bias_x/y/z,     block -> user
//          accepted_count, mean_variance
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data      host -> block
//
// One attempt transaction is taken per cycle inside a window. The attempt
// that closes the window starts a finish, in which the restoring dividers
// step one bit per cycle; input ready is low during it. A stalled output
// holds the finish in its last step. Reset clears the accumulators, the
// counters and the registers to their defaults; cfg_ready is always high.
// ---------------------------------------------------------------------------
module gyro_static_bias_calibrator
    import gsbc_pkg::*;
#(
    parameter int WINDOW_LIMIT = WINDOW_LIMIT_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          read_ok,
    input  logic signed [SAMPLE_BITS-1:0] raw_x,
    input  logic signed [SAMPLE_BITS-1:0] raw_y,
    input  logic signed [SAMPLE_BITS-1:0] raw_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [OUTC_W-1:0]             outcome,
    output logic signed [BIAS_W-1:0]      bias_x,
    output logic signed [BIAS_W-1:0]      bias_y,
    output logic signed [BIAS_W-1:0]      bias_z,
    output logic [CNT_W-1:0]              accepted_count,
    output logic [VAR_W-1:0]              mean_variance,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int DW = 2 * SAMPLE_BITS + 18;

    logic [CNT_W-1:0]   window_reg;
    logic [CNT_W-1:0]   min_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [OLD_W-1:0]   old_x_reg;
    logic [OLD_W-1:0]   old_y_reg;
    logic [OLD_W-1:0]   old_z_reg;

    logic                     out_valid_reg;
    logic [OUTC_W-1:0]        outcome_reg;
    logic signed [BIAS_W-1:0] bias_x_reg, bias_y_reg, bias_z_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [VAR_W-1:0]         mv_reg;

    logic [OUTC_W-1:0]        outcome_next;
    logic signed [BIAS_W-1:0] bias_x_next, bias_y_next, bias_z_next;
    logic [VAR_W-1:0]         mv_next;

    lane_ctl_t                   ctl;
    logic [CNT_W-1:0]            n;
    logic                        out_free;
    logic signed [SAMPLE_BITS:0] m0, m1, m2;
    logic signed [BIAS_W-1:0]    lb0, lb1, lb2;
    logic [DW-1:0]               d0, d1, d2;
    logic [VAR_W-1:0]            mv;
    logic                        few;
    logic                        moving;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RST;
            min_reg    <= MIN_RST;
            limit_reg  <= LIMIT_RST;
            old_x_reg  <= '0;
            old_y_reg  <= '0;
            old_z_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW: window_reg <= cfg_data[CNT_W-1:0];
                REG_MIN:    min_reg    <= cfg_data[CNT_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_OLD_X:  old_x_reg  <= cfg_data[OLD_W-1:0];
                REG_OLD_Y:  old_y_reg  <= cfg_data[OLD_W-1:0];
                REG_OLD_Z:  old_z_reg  <= cfg_data[OLD_W-1:0];
                default:    ;
            endcase
        end
    end

    // remap axes as (y, -x, z)
    assign m0 = {raw_y[SAMPLE_BITS-1], raw_y};
    assign m1 = -$signed({raw_x[SAMPLE_BITS-1], raw_x});
    assign m2 = {raw_z[SAMPLE_BITS-1], raw_z};

    assign out_free = !out_valid_reg || out_ready;

    gsbc_ctrl #(
        .WINDOW_LIMIT (WINDOW_LIMIT),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .read_ok    (read_ok),
        .window_cfg (window_reg),
        .out_free   (out_free),
        .ctl        (ctl),
        .n          (n)
    );

    gsbc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane0 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .smp   (m0),
        .n     (n),
        .bias  (lb0),
        .d     (d0)
    );

    gsbc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane1 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .smp   (m1),
        .n     (n),
        .bias  (lb1),
        .d     (d1)
    );

    gsbc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane2 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .smp   (m2),
        .n     (n),
        .bias  (lb2),
        .d     (d2)
    );

    gsbc_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .clk (clk),
        .ctl (ctl),
        .d0  (d0),
        .d1  (d1),
        .d2  (d2),
        .n   (n),
        .mv  (mv)
    );

    // decide the outcome and pick new or old bias
    assign few    = (n == '0) || (n < min_reg);
    assign moving = (mv >= {1'b0, limit_reg});

    always_comb
    begin
        if (few)
        begin
            outcome_next = OUTC_FEW;
            mv_next      = '0;
        end
        else if (moving)
        begin
            outcome_next = OUTC_MOVING;
            mv_next      = mv;
        end
        else
        begin
            outcome_next = OUTC_STILL;
            mv_next      = mv;
        end
        if (few || moving)
        begin
            bias_x_next = {old_x_reg[OLD_W-1], old_x_reg};
            bias_y_next = {old_y_reg[OLD_W-1], old_y_reg};
            bias_z_next = {old_z_reg[OLD_W-1], old_z_reg};
        end
        else
        begin
            bias_x_next = lb0;
            bias_y_next = lb1;
            bias_z_next = lb2;
        end
    end

    // hold the result transaction until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.clear)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            outcome_reg <= outcome_next;
            bias_x_reg  <= bias_x_next;
            bias_y_reg  <= bias_y_next;
            bias_z_reg  <= bias_z_next;
            count_reg   <= n;
            mv_reg      <= mv_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign outcome        = outcome_reg;
    assign bias_x         = bias_x_reg;
    assign bias_y         = bias_y_reg;
    assign bias_z         = bias_z_reg;
    assign accepted_count = count_reg;
    assign mean_variance  = mv_reg;

endmodule

// File: rtl/gsbc_lane.sv
// ---------------------------------------------------------------------------
// gsbc_lane
// One axis lane: registers and squares a mapped sample, accumulates sum and
// sum of squares, forms n*Q - S^2 and divides 256*|S| by n for the bias.
// ---------------------------------------------------------------------------
module gsbc_lane
    import gsbc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lane_ctl_t                     ctl,
    input  logic signed [SAMPLE_BITS:0]   smp,
    input  logic        [CNT_W-1:0]       n,
    output logic signed [BIAS_W-1:0]      bias,
    output logic [2*SAMPLE_BITS+17:0]     d
);

    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int SQW    = 2 * SAMPLE_BITS + 9;
    localparam int SUMW   = SAMPLE_BITS + 11;
    localparam int SMW    = SAMPLE_BITS + 10;
    localparam int NQW    = SQW + CNT_W;
    localparam int S2W    = 2 * SMW;
    localparam int DW     = 2 * SAMPLE_BITS + 18;
    localparam int NUMW   = DW + 2;

    logic signed [SAMPLE_BITS:0] smp_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic                        smp_vld_reg;
    logic signed [SUMW-1:0]      sum_reg;
    logic [SQW-1:0]              sqsum_reg;
    logic [NQW-1:0]              nq_reg;
    logic [S2W-1:0]              s2_reg;
    logic [DW-1:0]               d_reg;
    logic [NUMW-1:0]             dq_reg;
    logic [CNT_W-1:0]            rem_reg;

    logic [SAMPLE_BITS:0]        smp_abs;
    logic [SAMPLE_BITS-1:0]      smp_mag;
    logic [SUMW-1:0]             sum_abs;
    logic [SMW-1:0]              sum_mag;
    logic [S2W-1:0]              diff;
    logic [CNT_W:0]              trial;
    logic                        ge;
    logic [BIAS_W-1:0]           q_low;

    // magnitude of the incoming sample and of the running sum
    assign smp_abs = smp[SAMPLE_BITS] ? -smp : smp;
    assign smp_mag = smp_abs[SAMPLE_BITS-1:0];
    assign sum_abs = sum_reg[SUMW-1] ? -sum_reg : sum_reg;
    assign sum_mag = sum_abs[SMW-1:0];

    // register the sample and its square
    always_ff @(posedge clk)
    begin
        if (ctl.smp_load)
        begin
            smp_reg <= smp;
            sq_reg  <= smp_mag * smp_mag;
        end
    end

    // accumulate the registered sample, clear at window end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_vld_reg <= 1'b0;
            sum_reg     <= '0;
            sqsum_reg   <= '0;
        end
        else
        begin
            smp_vld_reg <= ctl.smp_load;
            if (ctl.clear)
            begin
                sum_reg   <= '0;
                sqsum_reg <= '0;
            end
            else if (smp_vld_reg)
            begin
                sum_reg   <= sum_reg + SUMW'(smp_reg);
                sqsum_reg <= sqsum_reg + SQW'(sq_reg);
            end
        end
    end

    // form n*Q - S^2; the true value always fits DW bits
    assign diff = S2W'(nq_reg) - s2_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            nq_reg <= n * sqsum_reg;
            s2_reg <= sum_mag * sum_mag;
        end
        if (ctl.sub)
            d_reg <= diff[DW-1:0];
    end

    // restoring division of 256*|S| by n, one quotient bit per step
    assign trial = {rem_reg, dq_reg[NUMW-1]};
    assign ge    = (trial >= {1'b0, n});

    always_ff @(posedge clk)
    begin
        if (ctl.div_init)
        begin
            dq_reg  <= NUMW'({sum_mag, 8'b0});
            rem_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            dq_reg  <= {dq_reg[NUMW-2:0], ge};
            rem_reg <= ge ? CNT_W'(trial - {1'b0, n}) : trial[CNT_W-1:0];
        end
    end

    // restore the sign, truncating toward zero
    assign q_low = dq_reg[BIAS_W-1:0];
    assign bias  = sum_reg[SUMW-1] ? -$signed(q_low) : $signed(q_low);
    assign d     = d_reg;

endmodule

// File: rtl/gsbc_merge.sv
// ---------------------------------------------------------------------------
// gsbc_merge
// Merge stage: sums the lane deviations, forms 3*n*n and divides to get the
// mean per-axis variance, saturated to the output width.
// ---------------------------------------------------------------------------
module gsbc_merge
    import gsbc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                      clk,
    input  lane_ctl_t                 ctl,
    input  logic [2*SAMPLE_BITS+17:0] d0,
    input  logic [2*SAMPLE_BITS+17:0] d1,
    input  logic [2*SAMPLE_BITS+17:0] d2,
    input  logic [CNT_W-1:0]          n,
    output logic [VAR_W-1:0]          mv
);

    localparam int DW   = 2 * SAMPLE_BITS + 18;
    localparam int NUMW = DW + 2;

    logic [2*CNT_W-1:0] nn_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [NUMW-1:0]    dq_reg;
    logic [DEN_W-1:0]   rem_reg;

    logic [NUMW-1:0]    num;
    logic [DEN_W:0]     trial;
    logic               ge;

    // build the divisor 3*n*n
    always_ff @(posedge clk)
    begin
        if (ctl.mul)
            nn_reg <= n * n;
        if (ctl.sub)
            den_reg <= DEN_W'({nn_reg, 1'b0}) + DEN_W'(nn_reg);
    end

    // combine the three lanes
    assign num = NUMW'(d0) + NUMW'(d1) + NUMW'(d2);

    // restoring division, one quotient bit per step
    assign trial = {rem_reg, dq_reg[NUMW-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (ctl.div_init)
        begin
            dq_reg  <= num;
            rem_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            dq_reg  <= {dq_reg[NUMW-2:0], ge};
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    // saturate the quotient
    assign mv = (|dq_reg[NUMW-1:VAR_W]) ? {VAR_W{1'b1}} : dq_reg[VAR_W-1:0];

endmodule

// File: rtl/gsbc_ctrl.sv
// ---------------------------------------------------------------------------
// gsbc_ctrl
// Sequencer: counts attempts and accepted samples, closes the window and
// steps the lanes and merge stage through the end-of-window arithmetic.
// ---------------------------------------------------------------------------
module gsbc_ctrl
    import gsbc_pkg::*;
#(
    parameter int WINDOW_LIMIT = WINDOW_LIMIT_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             read_ok,
    input  logic [CNT_W-1:0] window_cfg,
    input  logic             out_free,
    output lane_ctl_t        ctl,
    output logic [CNT_W-1:0] n
);

    localparam int NUMW    = 2 * SAMPLE_BITS + 20;
    localparam int DIV_CW  = $clog2(NUMW);
    localparam int WIN_CAP = (WINDOW_LIMIT < 1023) ? WINDOW_LIMIT : 1023;
    localparam logic [CNT_W-1:0]  WIN_CAP_V = CNT_W'(WIN_CAP);
    localparam logic [DIV_CW-1:0] DIV_LAST  = DIV_CW'(NUMW - 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   att_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [DIV_CW-1:0]  cnt_reg;

    logic [CNT_W-1:0]   win;
    logic               accept;
    logic               close;

    // clamp the window length
    always_comb
    begin
        if (window_cfg == '0)
            win = CNT_W'(1);
        else if (window_cfg > WIN_CAP_V)
            win = WIN_CAP_V;
        else
            win = window_cfg;
    end

    assign accept = in_valid && in_ready;
    assign close  = accept && (({1'b0, att_reg} + 1'b1) >= {1'b0, win});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM: if (close) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUB;
            ST_SUB:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == DIV_LAST) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_ACCUM;
            default:  state_next = ST_ACCUM;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        ctl          = '0;
        case (state_reg)
            ST_ACCUM:
            begin
                in_ready     = 1'b1;
                ctl.smp_load = in_valid && read_ok;
            end
            ST_MUL:  ctl.mul      = 1'b1;
            ST_SUB:  ctl.sub      = 1'b1;
            ST_SUM:  ctl.div_init = 1'b1;
            ST_DIV:  ctl.div_step = 1'b1;
            ST_DONE: ctl.clear    = out_free;
            default: ctl          = '0;
        endcase
    end

    // hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            att_reg   <= '0;
            n_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.clear)
            begin
                att_reg <= '0;
                n_reg   <= '0;
            end
            else
            begin
                if (accept)
                    att_reg <= att_reg + 1'b1;
                if (ctl.smp_load)
                    n_reg <= n_reg + 1'b1;
            end
            if (ctl.div_step)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
        end
    end

    assign n = n_reg;

endmodule

// File: sim/gyro_static_bias_calibrator_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gyro_static_bias_calibrator_test
// Self-checking bench for the gyro bias calibrator. A scoreboard class keeps
// its own copy of the window accumulators and the registers, predicts one
// result per closed window, and compares each output transaction field by
// field. Directed windows hit the field extremes and the corner cases, then
// random phases reprogram the block and stream windows of mixed content under
// random sender gaps, receiver stalls and one long output hold-off.
// ---------------------------------------------------------------------------
module gyro_static_bias_calibrator_test;
    import gsbc_pkg::*;

    localparam int SAMPLE_W        = SAMPLE_BITS_DEF;
    localparam int RAW_MAX         = 32767;
    localparam int RAW_MIN         = -32768;
    localparam int OLD_MAX         = 8388607;
    localparam int OLD_MIN         = -8388608;
    localparam int FINISH_SLACK    = 100;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int TARGET_ITEMS    = 2000;
    localparam int TARGET_RESULTS  = 48;
    localparam int HOLD_OFF_CYCLES = 500;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [LIMIT_W-1:0]   LIMIT_MAX   = '1;

    typedef longint unsigned u64_t;

    typedef enum int {STYLE_STILL, STYLE_WILD, STYLE_EXTREME, STYLE_DEAD} sample_style_t;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    typedef struct packed {
        logic [OUTC_W-1:0]        outcome;
        logic [2:0][BIAS_W-1:0]   bias;
        logic [CNT_W-1:0]         count;
        logic [VAR_W-1:0]         variance;
    } calib_result_t;

    // -----------------------------------------------------------------------
    // Scoreboard: window predictor and queue of pending calibration results
    // -----------------------------------------------------------------------
    class calib_scoreboard;
        logic [CNT_W-1:0]   window_cfg;
        logic [CNT_W-1:0]   min_cfg;
        logic [LIMIT_W-1:0] limit_cfg;
        logic [OLD_W-1:0]   old_bias [3];

        longint             axis_sum [3];
        u64_t               axis_sq [3];
        int                 accepted;
        int                 attempts;

        calib_result_t      window_results [$];
        int                 windows_checked;
        int                 errors;

        function new();
            window_cfg = WINDOW_RST;
            min_cfg    = MIN_RST;
            limit_cfg  = LIMIT_RST;
            for (int i = 0; i < 3; i++)
                old_bias[i] = '0;
            windows_checked = 0;
            errors = 0;
            clear_window();
        endfunction

        function void clear_window();
            for (int i = 0; i < 3; i++)
            begin
                axis_sum[i] = 0;
                axis_sq[i]  = 0;
            end
            accepted = 0;
            attempts = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WINDOW: window_cfg  = data[CNT_W-1:0];
                REG_MIN:    min_cfg     = data[CNT_W-1:0];
                REG_LIMIT:  limit_cfg   = data[LIMIT_W-1:0];
                REG_OLD_X:  old_bias[0] = data[OLD_W-1:0];
                REG_OLD_Y:  old_bias[1] = data[OLD_W-1:0];
                REG_OLD_Z:  old_bias[2] = data[OLD_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return window_results.size();
        endfunction

        // accumulate one attempt; close the window and predict its result
        function void note_attempt(logic ok, logic signed [SAMPLE_W-1:0] x,
                                   logic signed [SAMPLE_W-1:0] y,
                                   logic signed [SAMPLE_W-1:0] z);
            longint        mapped [3];
            int            win;
            calib_result_t r;
            u64_t          num;
            u64_t          den;
            u64_t          mv;
            longint        q;
            win = (window_cfg == 0) ? 1 : int'(window_cfg);
            if (win > WINDOW_LIMIT_DEF)
                win = WINDOW_LIMIT_DEF;
            if (ok)
            begin
                // remap axes as (y, -x, z)
                mapped[0] = longint'(y);
                mapped[1] = -longint'(x);
                mapped[2] = longint'(z);
                for (int i = 0; i < 3; i++)
                begin
                    axis_sum[i] += mapped[i];
                    axis_sq[i]  += u64_t'(mapped[i] * mapped[i]);
                end
                accepted++;
            end
            attempts++;
            if (attempts < win)
                return;

            r.count    = accepted[CNT_W-1:0];
            r.variance = '0;
            if (accepted == 0 || accepted < int'(min_cfg))
            begin
                r.outcome = OUTC_FEW;
                for (int i = 0; i < 3; i++)
                    r.bias[i] = {old_bias[i][OLD_W-1], old_bias[i]};
            end
            else
            begin
                num = 0;
                den = 3 * u64_t'(accepted) * u64_t'(accepted);
                for (int i = 0; i < 3; i++)
                    num += u64_t'(accepted) * axis_sq[i] - u64_t'(axis_sum[i] * axis_sum[i]);
                mv = num / den;
                if (mv > 64'h7FFF_FFFF)
                    mv = 64'h7FFF_FFFF;
                r.variance = mv[VAR_W-1:0];
                if (mv >= u64_t'(limit_cfg))
                begin
                    r.outcome = OUTC_MOVING;
                    for (int i = 0; i < 3; i++)
                        r.bias[i] = {old_bias[i][OLD_W-1], old_bias[i]};
                end
                else
                begin
                    // mean in Q.8, truncated toward zero
                    r.outcome = OUTC_STILL;
                    for (int i = 0; i < 3; i++)
                    begin
                        q = (axis_sum[i] * 256) / longint'(accepted);
                        r.bias[i] = q[BIAS_W-1:0];
                    end
                end
            end
            window_results = {window_results, r};
            clear_window();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(calib_result_t got);
            calib_result_t want;
            if (window_results.size() == 0)
            begin
                report($sformatf("result transaction with no window pending (outcome %0d)",
                                 got.outcome));
                return;
            end
            want = window_results.pop_front();
            windows_checked++;
            if (got.outcome != want.outcome)
                report($sformatf("window %0d: outcome %0d, want %0d",
                                 windows_checked, got.outcome, want.outcome));
            for (int i = 0; i < 3; i++)
                if (got.bias[i] != want.bias[i])
                    report($sformatf("window %0d: bias axis %0d is %0d, want %0d",
                                     windows_checked, i, $signed(got.bias[i]),
                                     $signed(want.bias[i])));
            if (got.count != want.count)
                report($sformatf("window %0d: accepted_count %0d, want %0d",
                                 windows_checked, got.count, want.count));
            if (got.variance != want.variance)
                report($sformatf("window %0d: mean_variance %0d, want %0d",
                                 windows_checked, got.variance, want.variance));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // Signals and block under test
    // -----------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       read_ok;
    logic signed [SAMPLE_W-1:0] raw_x;
    logic signed [SAMPLE_W-1:0] raw_y;
    logic signed [SAMPLE_W-1:0] raw_z;
    logic                       out_valid;
    logic                       out_ready;
    logic [OUTC_W-1:0]          outcome;
    logic signed [BIAS_W-1:0]   bias_x;
    logic signed [BIAS_W-1:0]   bias_y;
    logic signed [BIAS_W-1:0]   bias_z;
    logic [CNT_W-1:0]           accepted_count;
    logic [VAR_W-1:0]           mean_variance;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    calib_scoreboard sb;
    calib_result_t   observed;
    int              items_sent;
    int              burst_left;
    int              cycle_count;
    bit              gaps_on;
    bit              hold_off_now;

    gyro_static_bias_calibrator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .read_ok        (read_ok),
        .raw_x          (raw_x),
        .raw_y          (raw_y),
        .raw_z          (raw_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .outcome        (outcome),
        .bias_x         (bias_x),
        .bias_y         (bias_y),
        .bias_z         (bias_z),
        .accepted_count (accepted_count),
        .mean_variance  (mean_variance),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------
    // drop input valid and hold it low for a number of cycles
    task automatic pause_input(int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // offer one attempt transaction and wait until it is taken
    task automatic send_sample(logic ok, logic signed [SAMPLE_W-1:0] x,
                               logic signed [SAMPLE_W-1:0] y,
                               logic signed [SAMPLE_W-1:0] z);
        @(negedge clk);
        in_valid <= 1'b1;
        read_ok  <= ok;
        raw_x    <= x;
        raw_y    <= y;
        raw_z    <= z;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_attempt(ok, x, y, z);
        items_sent++;
        // end the burst with a random gap
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                pause_input($urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
            else
                burst_left--;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain all pending results, then let any finish run out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (FINISH_SLACK) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_axis(sample_style_t style,
                                                             int center, int amp);
        int v;
        case (style)
            STYLE_WILD, STYLE_DEAD:
                v = $urandom_range(0, 65535) - 32768;
            STYLE_EXTREME:
                case ($urandom_range(0, 4))
                    0: v = RAW_MIN;
                    1: v = RAW_MAX;
                    2: v = -1;
                    3: v = 0;
                    default: v = 1;
                endcase
            default:
                v = center + int'($urandom_range(0, 2 * amp)) - amp;
        endcase
        if (v > RAW_MAX)
            v = RAW_MAX;
        if (v < RAW_MIN)
            v = RAW_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    // stream a run of attempts with one content style
    task automatic send_window(int count);
        sample_style_t style;
        int            pick;
        int            cx;
        int            cy;
        int            cz;
        int            amp;
        logic          ok;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            style = STYLE_STILL;
        else if (pick < 7)
            style = STYLE_WILD;
        else if (pick < 9)
            style = STYLE_EXTREME;
        else
            style = STYLE_DEAD;
        cx  = $urandom_range(0, 65535) - 32768;
        cy  = $urandom_range(0, 65535) - 32768;
        cz  = $urandom_range(0, 65535) - 32768;
        amp = $urandom_range(0, 64);
        for (int k = 0; k < count; k++)
        begin
            if (style == STYLE_DEAD)
                ok = ($urandom_range(0, 7) == 0);
            else
                ok = ($urandom_range(0, 15) != 0);
            send_sample(ok, draw_axis(style, cx, amp), draw_axis(style, cy, amp),
                        draw_axis(style, cz, amp));
        end
    endtask

    // -----------------------------------------------------------------------
    // Stimulus phases
    // -----------------------------------------------------------------------
    task automatic run_directed();
        gaps_on = 1'b0;
        // single-attempt windows at the sample extremes, then a failed read
        write_reg(REG_WINDOW, 1);
        write_reg(REG_MIN, 1);
        write_reg(REG_LIMIT, LIMIT_MAX);
        write_reg(REG_OLD_X, 1000);
        write_reg(REG_OLD_Y, -2000);
        write_reg(REG_OLD_Z, 3);
        send_sample(1'b1, RAW_MIN, RAW_MAX, RAW_MIN);
        send_sample(1'b1, RAW_MAX, RAW_MIN, RAW_MAX);
        send_sample(1'b1, 0, 0, 0);
        send_sample(1'b0, RAW_MAX, RAW_MIN, -1);
        settle();

        // window of zero acts as one; no samples is too few even with min zero
        write_reg(REG_WINDOW, 0);
        write_reg(REG_MIN, 0);
        write_reg(REG_OLD_X, OLD_MIN);
        write_reg(REG_OLD_Y, OLD_MAX);
        write_reg(REG_OLD_Z, -1);
        send_sample(1'b0, RAW_MIN, RAW_MIN, RAW_MAX);
        send_sample(1'b1, -5, 7, 9);
        settle();

        // variance equal to the limit is moving, one below the limit is still
        write_reg(REG_WINDOW, 2);
        write_reg(REG_MIN, 1);
        write_reg(REG_LIMIT, 12);
        send_sample(1'b1, 0, 0, 0);
        send_sample(1'b1, 0, 12, 0);
        settle();
        write_reg(REG_LIMIT, 13);
        send_sample(1'b1, 0, 0, 0);
        send_sample(1'b1, 0, 12, 0);
        settle();

        // a limit of zero flags even a flat window as moving
        write_reg(REG_LIMIT, 0);
        send_sample(1'b1, 3, 3, 3);
        send_sample(1'b1, 3, 3, 3);
        settle();

        // failed reads use up the window but add no samples
        write_reg(REG_WINDOW, 3);
        write_reg(REG_MIN, 3);
        write_reg(REG_LIMIT, LIMIT_MAX);
        send_sample(1'b1, 100, -100, 50);
        send_sample(1'b0, 1, 2, 3);
        send_sample(1'b1, 90, -110, 40);
        settle();

        // shrink the window below the attempts already taken
        write_reg(REG_WINDOW, 10);
        write_reg(REG_MIN, 1);
        repeat (5) send_sample(1'b1, draw_axis(STYLE_WILD, 0, 0),
                               draw_axis(STYLE_WILD, 0, 0), draw_axis(STYLE_WILD, 0, 0));
        settle();
        write_reg(REG_WINDOW, 3);
        send_sample(1'b1, -7, 8, -9);
        gaps_on = 1'b1;
    endtask

    // hold the output off while single-attempt windows keep coming
    task automatic run_pressure_phase();
        settle();
        write_reg(REG_WINDOW, 1);
        write_reg(REG_MIN, 1);
        gaps_on = 1'b0;
        hold_off_now = 1'b1;
        repeat (40) send_sample(1'b1, draw_axis(STYLE_WILD, 0, 0),
                                draw_axis(STYLE_WILD, 0, 0), draw_axis(STYLE_WILD, 0, 0));
    endtask

    // one window at the largest size
    task automatic run_full_window_phase();
        settle();
        write_reg(REG_WINDOW, WINDOW_LIMIT_DEF);
        write_reg(REG_MIN, $urandom_range(0, WINDOW_LIMIT_DEF));
        write_reg(REG_LIMIT, $urandom_range(0, 4000));
        gaps_on = 1'b1;
        send_window(WINDOW_LIMIT_DEF);
    endtask

    task automatic run_random_phase();
        int                   pick;
        int                   win;
        int                   eff_win;
        int                   nwin;
        logic [CFG_IDX_W-1:0] old_idx;
        settle();
        pick = $urandom_range(0, 15);
        if (pick == 0)
            win = 0;
        else if (pick <= 10)
            win = $urandom_range(1, 16);
        else if (pick <= 13)
            win = $urandom_range(17, 64);
        else
            win = $urandom_range(65, 160);
        eff_win = (win == 0) ? 1 : win;
        write_reg(REG_WINDOW, win);

        if ($urandom_range(0, 3) != 0)
        begin
            case ($urandom_range(0, 7))
                0: write_reg(REG_MIN, 0);
                1: write_reg(REG_MIN, 1023);
                2: write_reg(REG_MIN, $urandom_range(0, 1023));
                default: write_reg(REG_MIN, $urandom_range(1, eff_win));
            endcase
        end
        if ($urandom_range(0, 3) != 0)
        begin
            case ($urandom_range(0, 7))
                0: write_reg(REG_LIMIT, 0);
                1: write_reg(REG_LIMIT, LIMIT_MAX);
                2: write_reg(REG_LIMIT, $urandom_range(0, LIMIT_MAX));
                default: write_reg(REG_LIMIT, $urandom_range(0, 3000));
            endcase
        end
        for (int i = 0; i < 3; i++)
        begin
            old_idx = CFG_IDX_W'(int'(REG_OLD_X) + i);
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 5))
                    0: write_reg(old_idx, OLD_MIN);
                    1: write_reg(old_idx, OLD_MAX);
                    default: write_reg(old_idx, $urandom_range(0, 24'hFF_FFFF));
                endcase
            end
        end
        // unmapped indexes must leave every register alone
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());

        gaps_on = ($urandom_range(0, 3) != 0);
        nwin = $urandom_range(1, 5);
        repeat (nwin) send_window(eff_win);
        // leave a partly filled window for the next setting
        if (eff_win > 1 && $urandom_range(0, 3) == 0)
            send_window($urandom_range(1, eff_win - 1));
    endtask

    // -----------------------------------------------------------------------
    // Receiver: stall patterns plus one long hold-off on request
    // -----------------------------------------------------------------------
    initial
    begin : receiver
        int       hold_left;
        int       mode_left;
        int       tick;
        rx_mode_t rx_mode;
        hold_left = 0;
        mode_left = 0;
        tick      = 0;
        rx_mode   = RX_ALWAYS;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_off_now)
            begin
                hold_off_now = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(40, 300);
                end
                mode_left--;
                case (rx_mode)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_COIN:   out_ready <= $urandom_range(0, 1);
                    RX_SPARSE: out_ready <= (tick % 4 == 0);
                    default:   out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // check every result transaction at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            observed.outcome  = outcome;
            observed.bias[0]  = bias_x;
            observed.bias[1]  = bias_y;
            observed.bias[2]  = bias_z;
            observed.count    = accepted_count;
            observed.variance = mean_variance;
            sb.check_result(observed);
        end
    end

    // stop a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("gyro_static_bias_calibrator_test: done, errors");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        int phase;
        sb           = new();
        items_sent   = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        hold_off_now = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        read_ok      = 1'b0;
        raw_x        = '0;
        raw_y        = '0;
        raw_z        = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        phase = 0;
        while (items_sent < TARGET_ITEMS || sb.windows_checked < TARGET_RESULTS)
        begin
            if (phase == 2)
                run_pressure_phase();
            else if (phase == 4)
                run_full_window_phase();
            else
                run_random_phase();
            phase++;
        end
        settle();

        if (sb.errors == 0)
            $display("gyro_static_bias_calibrator_test: done, clean");
        else
            $display("gyro_static_bias_calibrator_test: done, errors");
        $finish;
    end

endmodule

// File: gyro_static_bias_calibrator.f
rtl/gsbc_pkg.sv
rtl/gsbc_lane.sv
rtl/gsbc_merge.sv
rtl/gsbc_ctrl.sv
rtl/gyro_static_bias_calibrator.sv
sim/gyro_static_bias_calibrator_test.sv
